FILE: rtl/rigid_body_drag_integrator_defines.svh
`ifndef RIGID_BODY_DRAG_INTEGRATOR_DEFINES_SVH
`define RIGID_BODY_DRAG_INTEGRATOR_DEFINES_SVH

// same-cycle implication
`define RBDI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbdi assertion failed");

// next-cycle implication
`define RBDI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbdi assertion failed");

`endif

FILE: rtl/rbdi_pkg.sv
package rbdi_pkg;

    typedef logic [1:0] t_axis;

    localparam t_axis AxisX = 2'd0;
    localparam t_axis AxisY = 2'd1;
    localparam t_axis AxisZ = 2'd2;

    localparam int unsigned DivSteps = 41;
    localparam logic [5:0]  DivLast  = 6'(DivSteps - 1);

    localparam logic [40:0] CapVal    = 41'h100_0000_0000;
    localparam logic [31:0] DeadZone  = 32'd655;
    localparam logic [30:0] MassReset = 31'd65536;
    localparam logic [30:0] DragReset = 31'd65536;

    localparam logic signed [42:0] SumMax = 43'sd2147483647;
    localparam logic signed [42:0] SumMin = -43'sd2147483648;

    typedef enum logic [0:0] {
        CFG_MASS = 1'b0,
        CFG_DRAG = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic        [30:0] dt;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } t_in_req;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] disp_x;
        logic signed [31:0] disp_y;
        logic signed [31:0] disp_z;
    } t_out_req;

    typedef enum logic [3:0] {
        DP_NOP      = 4'd0,
        DP_LOAD     = 4'd1,
        DP_SQ       = 4'd2,
        DP_SQ_CAP   = 4'd3,
        DP_ML_LO    = 4'd4,
        DP_ML_HI    = 4'd5,
        DP_ML_CAP   = 4'd6,
        DP_NET      = 4'd7,
        DP_DIV_INIT = 4'd8,
        DP_DIV_STEP = 4'd9,
        DP_DIV_END  = 4'd10,
        DP_VEL      = 4'd11,
        DP_DISP_MUL = 4'd12,
        DP_DISP     = 4'd13
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        t_axis  axis;
        logic   use_dt;
        logic   capture;
        logic   publish;
    } t_dp_cmd;

endpackage

FILE: rtl/rbdi_ctrl.sv
`include "rigid_body_drag_integrator_defines.svh"

module rbdi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output rbdi_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_LOAD     = 18'h00002,
        S_SQ       = 18'h00004,
        S_SQ_CAP   = 18'h00008,
        S_DRG_LO   = 18'h00010,
        S_DRG_HI   = 18'h00020,
        S_DRG_CAP  = 18'h00040,
        S_NET      = 18'h00080,
        S_DIV_INIT = 18'h00100,
        S_DIV_STEP = 18'h00200,
        S_DIV_END  = 18'h00400,
        S_DV_LO    = 18'h00800,
        S_DV_HI    = 18'h01000,
        S_DV_CAP   = 18'h02000,
        S_VEL      = 18'h04000,
        S_DISP_MUL = 18'h08000,
        S_DISP     = 18'h10000,
        S_DONE     = 18'h20000
    } t_state;

    t_state          r_state, n_state;
    rbdi_pkg::t_axis r_axis, n_axis;
    logic [5:0]      r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;

    logic w_in_accept;
    logic w_publish;

    assign w_in_accept = i_in_valid && (r_state == S_IDLE);
    assign w_publish   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_LOAD;
                    n_axis  = rbdi_pkg::AxisX;
                end
            end
            S_LOAD:     n_state = S_SQ;
            S_SQ:       n_state = S_SQ_CAP;
            S_SQ_CAP:   n_state = S_DRG_LO;
            S_DRG_LO:   n_state = S_DRG_HI;
            S_DRG_HI:   n_state = S_DRG_CAP;
            S_DRG_CAP:  n_state = S_NET;
            S_NET:      n_state = S_DIV_INIT;
            S_DIV_INIT: begin
                n_state = S_DIV_STEP;
                n_cnt   = '0;
            end
            S_DIV_STEP: begin
                if (r_cnt == rbdi_pkg::DivLast) begin
                    n_state = S_DIV_END;
                end else begin
                    n_cnt = r_cnt + 6'd1;
                end
            end
            S_DIV_END:  n_state = S_DV_LO;
            S_DV_LO:    n_state = S_DV_HI;
            S_DV_HI:    n_state = S_DV_CAP;
            S_DV_CAP:   n_state = S_VEL;
            S_VEL:      n_state = S_DISP_MUL;
            S_DISP_MUL: n_state = S_DISP;
            S_DISP: begin
                if (r_axis == rbdi_pkg::AxisZ) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_LOAD;
                    n_axis  = r_axis + 2'd1;
                end
            end
            S_DONE: begin
                if (w_publish) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (w_publish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_comb begin
        o_cmd.op      = rbdi_pkg::DP_NOP;
        o_cmd.axis    = r_axis;
        o_cmd.use_dt  = (r_state == S_DV_LO) || (r_state == S_DV_HI) || (r_state == S_DV_CAP);
        o_cmd.capture = w_in_accept;
        o_cmd.publish = w_publish;
        case (r_state)
            S_LOAD:             o_cmd.op = rbdi_pkg::DP_LOAD;
            S_SQ:               o_cmd.op = rbdi_pkg::DP_SQ;
            S_SQ_CAP:           o_cmd.op = rbdi_pkg::DP_SQ_CAP;
            S_DRG_LO, S_DV_LO:  o_cmd.op = rbdi_pkg::DP_ML_LO;
            S_DRG_HI, S_DV_HI:  o_cmd.op = rbdi_pkg::DP_ML_HI;
            S_DRG_CAP, S_DV_CAP: o_cmd.op = rbdi_pkg::DP_ML_CAP;
            S_NET:              o_cmd.op = rbdi_pkg::DP_NET;
            S_DIV_INIT:         o_cmd.op = rbdi_pkg::DP_DIV_INIT;
            S_DIV_STEP:         o_cmd.op = rbdi_pkg::DP_DIV_STEP;
            S_DIV_END:          o_cmd.op = rbdi_pkg::DP_DIV_END;
            S_VEL:              o_cmd.op = rbdi_pkg::DP_VEL;
            S_DISP_MUL:         o_cmd.op = rbdi_pkg::DP_DISP_MUL;
            S_DISP:             o_cmd.op = rbdi_pkg::DP_DISP;
            default:            o_cmd.op = rbdi_pkg::DP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= rbdi_pkg::AxisX;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    `RBDI_ASSERT_IMP(a_axis_range, i_clk, i_rst_n, 1'b1, r_axis == rbdi_pkg::AxisX || r_axis == rbdi_pkg::AxisY || r_axis == rbdi_pkg::AxisZ)
    `RBDI_ASSERT_NXT(a_accept_starts_x, i_clk, i_rst_n, w_in_accept, r_state == S_LOAD && r_axis == rbdi_pkg::AxisX)
    `RBDI_ASSERT_IMP(a_done_after_z, i_clk, i_rst_n, r_state == S_DONE, r_axis == rbdi_pkg::AxisZ)
    `RBDI_ASSERT_IMP(a_div_count, i_clk, i_rst_n, r_state == S_DIV_STEP, r_cnt <= rbdi_pkg::DivLast)
    `RBDI_ASSERT_IMP(a_valid_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)

endmodule

FILE: rtl/rbdi_dp.sv
`include "rigid_body_drag_integrator_defines.svh"

module rbdi_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rbdi_pkg::t_dp_cmd  i_cmd,
    input  rbdi_pkg::t_in_req  i_in_req,
    output rbdi_pkg::t_out_req o_out_req,
    input  logic               i_cfg_valid,
    input  rbdi_pkg::t_cfg_idx i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic [30:0]        r_mass, n_mass;
    logic [30:0]        r_drag, n_drag;
    logic signed [31:0] r_vel_x, n_vel_x;
    logic signed [31:0] r_vel_y, n_vel_y;
    logic signed [31:0] r_vel_z, n_vel_z;

    rbdi_pkg::t_in_req  r_in, n_in;
    logic signed [31:0] r_v, n_v;
    logic signed [31:0] r_f, n_f;
    logic signed [31:0] r_nv, n_nv;
    logic [63:0]        r_prod, n_prod;
    logic [47:0]        r_acc, n_acc;
    logic [40:0]        r_a, n_a;
    logic [40:0]        r_q, n_q;
    logic [30:0]        r_rem, n_rem;
    logic               r_neg, n_neg;
    logic               r_ovf, n_ovf;
    rbdi_pkg::t_out_req r_res, n_res;
    rbdi_pkg::t_out_req r_out, n_out;

    logic [30:0]        w_div;
    logic [30:0]        w_b;
    logic [31:0]        w_vm;
    logic [31:0]        w_nvm;
    logic [31:0]        w_mul_a;
    logic [31:0]        w_mul_b;
    logic [63:0]        w_prod;
    logic signed [31:0] w_vel_sel;
    logic signed [31:0] w_force_sel;
    logic [40:0]        w_sq_cap;
    logic [48:0]        w_ml_sum;
    logic [40:0]        w_ml_cap;
    logic [42:0]        w_dm;
    logic signed [42:0] w_drag;
    logic signed [42:0] w_net;
    logic [42:0]        w_nm;
    logic [40:0]        w_nm_cap;
    logic [15:0]        w_rem_init;
    logic [31:0]        w_t;
    logic [31:0]        w_sub;
    logic               w_ge;
    logic [40:0]        w_q_cap;
    logic signed [42:0] w_dv;
    logic signed [42:0] w_sum;
    logic signed [31:0] w_sat;
    logic [31:0]        w_sat_mag;
    logic signed [31:0] w_new_v;
    logic [46:0]        w_pm;
    logic signed [31:0] w_disp;

    assign o_out_req = r_out;

    // zero mass divides by one
    assign w_div = (r_mass == '0) ? 31'd1 : r_mass;
    assign w_b   = i_cmd.use_dt ? r_in.dt : r_drag;
    assign w_vm  = r_v[31] ? (32'd0 - $unsigned(r_v)) : $unsigned(r_v);
    assign w_nvm = r_nv[31] ? (32'd0 - $unsigned(r_nv)) : $unsigned(r_nv);

    always_comb begin
        case (i_cmd.axis)
            rbdi_pkg::AxisY: begin
                w_vel_sel   = r_vel_y;
                w_force_sel = r_in.force_y;
            end
            rbdi_pkg::AxisZ: begin
                w_vel_sel   = r_vel_z;
                w_force_sel = r_in.force_z;
            end
            default: begin
                w_vel_sel   = r_vel_x;
                w_force_sel = r_in.force_x;
            end
        endcase
    end

    // shared multiplier
    always_comb begin
        case (i_cmd.op)
            rbdi_pkg::DP_SQ: begin
                w_mul_a = w_vm;
                w_mul_b = w_vm;
            end
            rbdi_pkg::DP_ML_LO: begin
                w_mul_a = r_a[31:0];
                w_mul_b = {1'b0, w_b};
            end
            rbdi_pkg::DP_ML_HI: begin
                w_mul_a = {23'd0, r_a[40:32]};
                w_mul_b = {1'b0, w_b};
            end
            rbdi_pkg::DP_DISP_MUL: begin
                w_mul_a = w_nvm;
                w_mul_b = {1'b0, r_in.dt};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    assign w_sq_cap = (r_prod[63:16] > {7'd0, rbdi_pkg::CapVal}) ? rbdi_pkg::CapVal
                                                                : r_prod[56:16];

    // hi partial product in r_prod, shifted lo partial product in r_acc
    assign w_ml_sum = {8'd0, r_prod[24:0], 16'd0} + {1'b0, r_acc};
    assign w_ml_cap = ((r_prod[39:25] != '0) || (w_ml_sum > {8'd0, rbdi_pkg::CapVal}))
                      ? rbdi_pkg::CapVal : w_ml_sum[40:0];

    assign w_dm     = {2'b00, r_a};
    assign w_drag   = r_v[31] ? $signed(43'd0 - w_dm) : $signed(w_dm);
    assign w_net    = $signed({{11{r_f[31]}}, r_f}) - w_drag;
    assign w_nm     = w_net[42] ? (43'd0 - $unsigned(w_net)) : $unsigned(w_net);
    assign w_nm_cap = (w_nm > {2'd0, rbdi_pkg::CapVal}) ? rbdi_pkg::CapVal : w_nm[40:0];

    // restoring divider, one quotient bit per step
    assign w_rem_init = r_a[40:25];
    assign w_t        = {r_rem, r_q[40]};
    assign w_ge       = (w_t >= {1'b0, w_div});
    assign w_sub      = w_t - {1'b0, w_div};
    assign w_q_cap    = (r_ovf || (r_q > rbdi_pkg::CapVal)) ? rbdi_pkg::CapVal : r_q;

    assign w_dv  = r_neg ? $signed(43'd0 - {2'b00, r_a}) : $signed({2'b00, r_a});
    assign w_sum = $signed({{11{r_v[31]}}, r_v}) + w_dv;

    always_comb begin
        if (w_sum > rbdi_pkg::SumMax) begin
            w_sat = 32'sh7FFF_FFFF;
        end else if (w_sum < rbdi_pkg::SumMin) begin
            w_sat = 32'sh8000_0000;
        end else begin
            w_sat = w_sum[31:0];
        end
    end

    assign w_sat_mag = w_sat[31] ? (32'd0 - $unsigned(w_sat)) : $unsigned(w_sat);
    assign w_new_v   = (w_sat_mag <= rbdi_pkg::DeadZone) ? 32'sd0 : w_sat;

    assign w_pm = r_prod[62:16];

    always_comb begin
        if (r_nv[31]) begin
            if (w_pm > 47'h0000_8000_0000) begin
                w_disp = 32'sh8000_0000;
            end else begin
                w_disp = $signed(32'd0 - w_pm[31:0]);
            end
        end else begin
            if (w_pm > 47'h0000_7FFF_FFFF) begin
                w_disp = 32'sh7FFF_FFFF;
            end else begin
                w_disp = $signed(w_pm[31:0]);
            end
        end
    end

    always_comb begin
        n_mass  = r_mass;
        n_drag  = r_drag;
        n_vel_x = r_vel_x;
        n_vel_y = r_vel_y;
        n_vel_z = r_vel_z;
        n_in    = r_in;
        n_v     = r_v;
        n_f     = r_f;
        n_nv    = r_nv;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_a     = r_a;
        n_q     = r_q;
        n_rem   = r_rem;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        n_res   = r_res;
        n_out   = r_out;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                rbdi_pkg::CFG_MASS: n_mass = i_cfg_data[30:0];
                rbdi_pkg::CFG_DRAG: n_drag = i_cfg_data[30:0];
                default: ;
            endcase
        end

        if (i_cmd.capture) begin
            n_in = i_in_req;
        end

        if (i_cmd.publish) begin
            n_out = r_res;
        end

        case (i_cmd.op)
            rbdi_pkg::DP_LOAD: begin
                n_v = w_vel_sel;
                n_f = w_force_sel;
            end
            rbdi_pkg::DP_SQ, rbdi_pkg::DP_ML_LO, rbdi_pkg::DP_DISP_MUL: begin
                n_prod = w_prod;
            end
            rbdi_pkg::DP_SQ_CAP: begin
                n_a = w_sq_cap;
            end
            rbdi_pkg::DP_ML_HI: begin
                n_acc  = r_prod[63:16];
                n_prod = w_prod;
            end
            rbdi_pkg::DP_ML_CAP: begin
                n_a = w_ml_cap;
            end
            rbdi_pkg::DP_NET: begin
                n_a   = w_nm_cap;
                n_neg = w_net[42];
            end
            rbdi_pkg::DP_DIV_INIT: begin
                n_rem = {15'd0, w_rem_init};
                n_q   = {r_a[24:0], 16'd0};
                n_ovf = ({15'd0, w_rem_init} >= w_div);
            end
            rbdi_pkg::DP_DIV_STEP: begin
                n_rem = w_ge ? w_sub[30:0] : w_t[30:0];
                n_q   = {r_q[39:0], w_ge};
            end
            rbdi_pkg::DP_DIV_END: begin
                n_a = w_q_cap;
            end
            rbdi_pkg::DP_VEL: begin
                n_nv = w_new_v;
                case (i_cmd.axis)
                    rbdi_pkg::AxisX: begin
                        n_vel_x     = w_new_v;
                        n_res.vel_x = w_new_v;
                    end
                    rbdi_pkg::AxisY: begin
                        n_vel_y     = w_new_v;
                        n_res.vel_y = w_new_v;
                    end
                    rbdi_pkg::AxisZ: begin
                        n_vel_z     = w_new_v;
                        n_res.vel_z = w_new_v;
                    end
                    default: ;
                endcase
            end
            rbdi_pkg::DP_DISP: begin
                case (i_cmd.axis)
                    rbdi_pkg::AxisX: n_res.disp_x = w_disp;
                    rbdi_pkg::AxisY: n_res.disp_y = w_disp;
                    rbdi_pkg::AxisZ: n_res.disp_z = w_disp;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass  <= rbdi_pkg::MassReset;
            r_drag  <= rbdi_pkg::DragReset;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_vel_z <= '0;
        end else begin
            r_mass  <= n_mass;
            r_drag  <= n_drag;
            r_vel_x <= n_vel_x;
            r_vel_y <= n_vel_y;
            r_vel_z <= n_vel_z;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in   <= n_in;
        r_v    <= n_v;
        r_f    <= n_f;
        r_nv   <= n_nv;
        r_prod <= n_prod;
        r_acc  <= n_acc;
        r_a    <= n_a;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_ovf  <= n_ovf;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    `RBDI_ASSERT_NXT(a_dead_zone, i_clk, i_rst_n, i_cmd.op == rbdi_pkg::DP_VEL, r_nv == 32'sd0 || w_nvm > rbdi_pkg::DeadZone)

endmodule

FILE: rtl/rigid_body_drag_integrator.sv
// channel   direction  handshake              payload
// in        input      i_in_valid/o_in_stall  i_in_req   (dt, force_x/y/z)
// out       output     o_out_valid/i_out_stall o_out_req (vel_x/y/z, disp_x/y/z)
// cfg       input      i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one item at a time: three axes in turn, plus accept and hand-off; no new item is accepted until the last is published
// each axis passes through the one-bit-per-cycle divider, with the shared multiplier used before and after it
// synchronous active-low reset zeroes the stored velocity and restores mass and drag to 1.0
// a stalled result holds in the output register while the next item is accepted

module rigid_body_drag_integrator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rbdi_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output rbdi_pkg::t_out_req o_out_req,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  rbdi_pkg::t_cfg_idx i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    rbdi_pkg::t_dp_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    rbdi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    rbdi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_req    (i_in_req),
        .o_out_req   (o_out_req),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

FILE: tb/tb_rigid_body_drag_integrator.sv
`timescale 1ns / 100ps

module tb_rigid_body_drag_integrator;

    localparam int BLOCK_CYCLES  = 170;
    localparam int TAIL_CYCLES   = 2 * BLOCK_CYCLES;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_LEN      = 1500;
    localparam int WATCHDOG      = 6000;
    localparam int MAX_GAP       = 18;
    localparam logic [63:0] CAP  = 64'd1 << 40;
    localparam logic [63:0] DEAD = 64'd655;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                in_valid = 1'b0;
    logic                in_stall;
    rbdi_pkg::t_in_req   in_req = '0;
    logic                out_valid;
    rbdi_pkg::t_out_req  out_req;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    rbdi_pkg::t_cfg_idx  cfg_index = rbdi_pkg::CFG_MASS;
    logic [31:0]         cfg_data = '0;

    int  in_wait = 0;
    int  in_accepts = 0;
    int  out_wait = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  no_idle = 1'b0;
    int  mismatches = 0;
    int  idle_cycles = 0;

    logic out_stall;
    assign out_stall = (out_wait != 0) || (hold_left != 0);

    // integrator state and registers as the block should hold them
    logic [63:0] mass_q = 64'd65536;
    logic [63:0] drag_q = 64'd65536;
    logic signed [31:0] vel_x_q = '0;
    logic signed [31:0] vel_y_q = '0;
    logic signed [31:0] vel_z_q = '0;

    rbdi_pkg::t_in_req  step_reqs[$];
    rbdi_pkg::t_out_req expected_motion[$];
    string field_names [6] = '{"vel_x", "vel_y", "vel_z", "disp_x", "disp_y", "disp_z"};

    rigid_body_drag_integrator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_req   (out_req),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] qmul_capped(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> 16;
        return (p > {64'd0, CAP}) ? CAP : p[63:0];
    endfunction

    function automatic void step_axis(input logic signed [31:0] v_old,
                                      input logic signed [31:0] force_in,
                                      input logic [63:0] dt,
                                      output logic signed [31:0] v_new,
                                      output logic signed [31:0] disp);
        logic signed [63:0] v, drag, net, dv, nv, pd;
        logic [63:0] vm, dm, nm, div, am, dvm, nvm, pm;
        v = v_old;
        vm = (v < 0) ? -v : v;
        dm = qmul_capped(qmul_capped(vm, vm), drag_q);
        drag = (v < 0) ? -$signed(dm) : $signed(dm);
        net = force_in - drag;
        nm = (net < 0) ? -net : net;
        if (nm > CAP) nm = CAP;
        div = (mass_q == 0) ? 64'd1 : mass_q;
        am = (nm << 16) / div;
        if (am > CAP) am = CAP;
        dvm = qmul_capped(am, dt);
        dv = (net < 0) ? -$signed(dvm) : $signed(dvm);
        nv = v + dv;
        if (nv > 64'sd2147483647) nv = 64'sd2147483647;
        else if (nv < -64'sd2147483648) nv = -64'sd2147483648;
        nvm = (nv < 0) ? -nv : nv;
        // dead zone around zero
        if (nvm <= DEAD) begin
            nv = 0;
            nvm = 0;
        end
        pm = (nvm * dt) >> 16;
        pd = (nv < 0) ? -$signed(pm) : $signed(pm);
        if (pd > 64'sd2147483647) pd = 64'sd2147483647;
        else if (pd < -64'sd2147483648) pd = -64'sd2147483648;
        v_new = nv[31:0];
        disp = pd[31:0];
    endfunction

    function automatic void predict_motion(input rbdi_pkg::t_in_req r);
        rbdi_pkg::t_out_req res;
        logic [63:0] dt;
        logic signed [31:0] v, d;
        dt = 64'(r.dt);
        step_axis(vel_x_q, r.force_x, dt, v, d);
        vel_x_q = v;
        res.vel_x = v;
        res.disp_x = d;
        step_axis(vel_y_q, r.force_y, dt, v, d);
        vel_y_q = v;
        res.vel_y = v;
        res.disp_y = d;
        step_axis(vel_z_q, r.force_z, dt, v, d);
        vel_z_q = v;
        res.vel_z = v;
        res.disp_z = d;
        expected_motion.push_back(res);
    endfunction

    function automatic void check_motion(input rbdi_pkg::t_out_req got);
        rbdi_pkg::t_out_req want;
        logic [5:0][31:0] w, g;
        if (expected_motion.size() == 0) begin
            if (mismatches < 10) $display("unexpected result %h", got);
            mismatches++;
        end else begin
            want = expected_motion.pop_front();
            w = want;
            g = got;
            for (int k = 0; k < 6; k++) begin
                if (w[5-k] !== g[5-k]) begin
                    if (mismatches < 10)
                        $display("%s mismatch: expected %0d got %0d", field_names[k],
                                 $signed(w[5-k]), $signed(g[5-k]));
                    mismatches++;
                end
            end
        end
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    function automatic logic [30:0] rand_dt();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 31'($urandom_range(1, 8192));
        else if (pick < 75) return 31'($urandom_range(8193, 262144));
        else if (pick < 85) return 31'($urandom() >> 1);
        else if (pick < 90) return 31'd0;
        else if (pick < 95) return 31'h7FFF_FFFF;
        else return 31'($urandom_range(0, 65536));
    endfunction

    function automatic logic [31:0] rand_force();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 32'(int'($urandom_range(0, 2097152)) - 1048576);
        else if (pick < 60) return $urandom();
        else if (pick < 70) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else if (pick < 80) return 32'd0;
        else if (pick < 92) return 32'(int'($urandom_range(0, 2800)) - 1400);
        else return 32'(int'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000);
    endfunction

    function automatic void queue_step(input logic [30:0] dt, input logic [31:0] fx,
                                       input logic [31:0] fy, input logic [31:0] fz);
        rbdi_pkg::t_in_req r;
        r.dt = dt;
        r.force_x = fx;
        r.force_y = fy;
        r.force_z = fz;
        step_reqs.push_back(r);
    endfunction

    task automatic drain();
        do @(negedge clk);
        while (step_reqs.size() != 0 || in_valid || expected_motion.size() != 0);
    endtask

    task automatic write_reg(input rbdi_pkg::t_cfg_idx idx, input logic [31:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rbdi_pkg::CFG_MASS) mass_q = 64'(data[30:0]);
        else drag_q = 64'(data[30:0]);
        @(negedge clk);
    endtask

    task automatic random_config();
        logic [30:0] m, k;
        int unsigned pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0, 1: m = 31'($urandom_range(16384, 1048576));
            2: m = 31'($urandom_range(1, 4096));
            default: m = 31'($urandom_range(1, 32'h7FFF_FFFF));
        endcase
        pick = $urandom_range(0, 4);
        case (pick)
            0, 1: k = 31'($urandom_range(0, 131072));
            2: k = 31'd0;
            default: k = 31'($urandom() >> 1);
        endcase
        if ($urandom_range(0, 1)) begin
            write_reg(rbdi_pkg::CFG_MASS, {1'($urandom_range(0, 1)), m});
            write_reg(rbdi_pkg::CFG_DRAG, {1'($urandom_range(0, 1)), k});
        end else begin
            write_reg(rbdi_pkg::CFG_DRAG, {1'($urandom_range(0, 1)), k});
            write_reg(rbdi_pkg::CFG_MASS, {1'($urandom_range(0, 1)), m});
        end
    endtask

    task automatic run_phase(input int n, input bit burst);
        @(negedge clk);
        no_idle = burst;
        repeat (n) queue_step(rand_dt(), rand_force(), rand_force(), rand_force());
        drain();
    endtask

    // request driver
    always @(posedge clk) begin : drive_steps
        int gap;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_wait <= 0;
        end else if (in_valid && !in_stall) begin
            predict_motion(in_req);
            in_accepts <= in_accepts + 1;
            gap = draw_gap();
            if (gap == 0 && step_reqs.size() != 0) begin
                in_req <= step_reqs.pop_front();
            end else begin
                in_valid <= 1'b0;
                in_wait <= gap;
            end
        end else if (!in_valid) begin
            if (in_wait != 0) begin
                in_wait <= in_wait - 1;
            end else if (step_reqs.size() != 0) begin
                in_req <= step_reqs.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_wait <= 0;
        end else if (out_valid && !out_stall) begin
            check_motion(out_req);
            out_wait <= draw_gap();
        end else if (out_valid && out_wait != 0) begin
            out_wait <= out_wait - 1;
        end
    end

    // long receiver hold-off to back up the input
    always @(posedge clk) begin
        if (!hold_done && in_accepts == HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG) begin
            $display("[rigid_body_drag_integrator] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of mass and drag
        queue_step(31'd65536, 32'sd65536, -32'sd65536, 32'sd0);
        queue_step(31'd1092, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd655);
        queue_step(31'd0, 32'sd0, 32'sd0, 32'sd0);
        run_phase(150, 1'b0);

        // unit mass, no drag: dead zone edges and saturation
        write_reg(rbdi_pkg::CFG_MASS, 32'h0001_0000);
        write_reg(rbdi_pkg::CFG_DRAG, 32'h8000_0000);
        queue_step(31'd65536, 32'sd655, -32'sd655, 32'sd656);
        queue_step(31'd65536, -32'sd656, 32'sd656, -32'sd1312);
        queue_step(31'd65536, 32'sd1, -32'sd1, 32'sd0);
        queue_step(31'd0, 32'sd0, 32'sd0, 32'sd0);
        queue_step(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd0);
        queue_step(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        queue_step(31'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'sd0);
        run_phase(250, 1'b1);

        // smallest mass, largest drag
        write_reg(rbdi_pkg::CFG_DRAG, 32'hFFFF_FFFF);
        write_reg(rbdi_pkg::CFG_MASS, 32'h0000_0001);
        queue_step(31'd65536, 32'sd0, 32'sd0, 32'sd0);
        queue_step(31'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd12345);
        queue_step(31'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0);
        queue_step(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, -32'sd1);
        run_phase(200, 1'b0);

        // largest mass, tiny drag
        write_reg(rbdi_pkg::CFG_MASS, 32'h7FFF_FFFF);
        write_reg(rbdi_pkg::CFG_DRAG, 32'h0000_0001);
        queue_step(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd0);
        queue_step(31'd65536, -32'sd1, 32'sd1, 32'sd0);
        run_phase(200, 1'b1);

        for (int p = 0; p < 6; p++) begin
            random_config();
            run_phase(190, p[0]);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_motion.size() == 0) begin
            $display("[rigid_body_drag_integrator] OK");
        end else begin
            $display("[rigid_body_drag_integrator] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/rbdi_pkg.sv
rtl/rbdi_ctrl.sv
rtl/rbdi_dp.sv
rtl/rigid_body_drag_integrator.sv
tb/tb_rigid_body_drag_integrator.sv
